// ===== hw/rtl/egcd_pkg.sv =====
// Shared types and constants for the Euclid GCD unit.
package egcd_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FIELD_W    = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef struct packed {
		logic [FIELD_W-1:0] operand_a;
		logic [FIELD_W-1:0] operand_b;
	} in_t;

	typedef struct packed {
		logic [FIELD_W-1:0] divisor_out;
		logic               zero_operand;
	} out_t;

	typedef struct packed {
		logic load;
		logic step;
		logic swap;
		logic capture;
	} dp_cmd_t;

	typedef struct packed {
		logic y_zero;
	} dp_sts_t;

endpackage

// ===== hw/rtl/egcd_datapath.sv =====
// Datapath of the Euclid GCD unit: operand pair, restoring divider and output register.
module egcd_datapath (
	input  logic            clk,
	input  egcd_pkg::in_t   src_data,
	input  egcd_pkg::dp_cmd_t cmd,
	output egcd_pkg::dp_sts_t sts,
	output egcd_pkg::out_t  dst_data
);
	import egcd_pkg::*;

	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;
	logic [DATA_WIDTH-1:0] d_q;
	logic [DATA_WIDTH-1:0] r_q;
	logic                  flag_q;
	out_t                  out_q;

	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH-1:0] r_next;
	logic [DATA_WIDTH-1:0] a_in;
	logic [DATA_WIDTH-1:0] b_in;

	assign a_in  = DATA_WIDTH'(src_data.operand_a);
	assign b_in  = DATA_WIDTH'(src_data.operand_b);
	assign trial = {r_q, d_q[DATA_WIDTH-1]};
	assign diff  = trial - {1'b0, y_q};
	// Restore when the shifted remainder is below the divisor.
	assign r_next = diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= a_in;
			y_q    <= b_in;
			d_q    <= a_in;
			r_q    <= '0;
			flag_q <= (b_in == '0);
		end else if (cmd.step) begin
			d_q <= {d_q[DATA_WIDTH-2:0], 1'b0};
			r_q <= r_next;
		end else if (cmd.swap) begin
			// (x, y) becomes (y, x mod y); the new dividend is the old divisor.
			x_q <= y_q;
			y_q <= r_q;
			d_q <= y_q;
			r_q <= '0;
		end
		if (cmd.capture) begin
			out_q.divisor_out  <= FIELD_W'(x_q);
			out_q.zero_operand <= flag_q;
		end
	end

	assign sts.y_zero = (y_q == '0);
	assign dst_data   = out_q;

endmodule

// ===== hw/rtl/egcd_ctrl.sv =====
// Controller of the Euclid GCD unit: sequences division steps and handles both handshakes.
module egcd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	output logic              dst_valid,
	input  logic              dst_stall,
	input  egcd_pkg::dp_sts_t sts,
	output egcd_pkg::dp_cmd_t cmd
);
	import egcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_NEXT,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             out_free;
	logic             cnt_last;

	assign out_free = !out_valid_q || !dst_stall;
	assign cnt_last = (cnt_q == CNT_W'(DATA_WIDTH - 1));

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load    = src_valid;
			ST_DIV:  cmd.step    = !sts.y_zero;
			ST_NEXT: cmd.swap    = 1'b1;
			ST_DONE: cmd.capture = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (!dst_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (src_valid) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					if (sts.y_zero) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_last) begin
							state_q <= ST_NEXT;
						end
					end
				end
				ST_NEXT: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DONE: begin
					// Hold until the output register is free for the transaction.
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign src_stall = (state_q != ST_IDLE);
	assign dst_valid = out_valid_q;

endmodule

// ===== hw/rtl/euclid_gcd_unit.sv =====
// Top level of the Euclid GCD unit.
//
//  channel | direction | handshake            | payload
//  src     | in        | src_valid/src_stall  | operand_a, operand_b
//  dst     | out       | dst_valid/dst_stall  | divisor_out, zero_operand
//
// The result is captured after k remainder steps, and the next input transaction is taken after
// that, k being the number of remainder steps (0 when operand_b is zero); each remainder comes
// from DATA_WIDTH steps of a one-bit-per-cycle restoring divider and a swap.
// Reset clears the controller and the output valid; operand registers are not reset.
// A finished result sits in the output register, so a new transaction is taken while it
// waits; a stalled output only holds the next result back once that one is done.
module euclid_gcd_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           src_valid,
	output logic           src_stall,
	input  egcd_pkg::in_t  src_data,
	output logic           dst_valid,
	input  logic           dst_stall,
	output egcd_pkg::out_t dst_data
);
	import egcd_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	egcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	egcd_datapath u_datapath (
		.clk      (clk),
		.src_data (src_data),
		.cmd      (cmd),
		.sts      (sts),
		.dst_data (dst_data)
	);

endmodule

// ===== verif/euclid_gcd_unit_tb.sv =====
// Self-checking testbench for the Euclid GCD unit: directed table, then randomized operands.
module euclid_gcd_unit_tb;
	import egcd_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int RESET_CYC   = 5;
	localparam int RANDOM_OPS  = 1750;
	localparam int MAX_WAIT    = 10;
	// Slowest item: about 46 remainder steps of DATA_WIDTH divider steps each.
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE_CYC  = 2 * DATA_WIDTH + 8;

	typedef struct packed {
		in_t  operands;
		logic known;
		out_t result;
	} vector_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   src_valid = 1'b0;
	logic   src_stall;
	in_t    src_data = '0;
	logic   dst_valid;
	logic   dst_stall = 1'b0;
	out_t   dst_data;

	out_t    pending_gcd_q [$];
	vector_t directed_vectors [$];
	int      error_count = 0;
	int      idle_cycles = 0;
	bit      steady_phase = 1'b0;

	euclid_gcd_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_data  (dst_data)
	);

	always #CLK_HALF clk = ~clk;

	function automatic out_t expected_gcd(in_t item);
		longint unsigned width_mask;
		longint unsigned x;
		longint unsigned y;
		longint unsigned rem;
		out_t            res;
		width_mask = ((64'd1 << (DATA_WIDTH - 1)) * 2) - 1;
		x = item.operand_a & width_mask;
		y = item.operand_b & width_mask;
		res.zero_operand = (y == 0);
		while (y != 0) begin
			rem = x % y;
			x = y;
			y = rem;
		end
		res.divisor_out = x[FIELD_W-1:0];
		return res;
	endfunction

	function automatic vector_t make_vector(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b,
			logic known, logic [FIELD_W-1:0] g, logic z);
		vector_t v;
		v.operands.operand_a = a;
		v.operands.operand_b = b;
		v.known = known;
		v.result.divisor_out = g;
		v.result.zero_operand = z;
		return v;
	endfunction

	function automatic in_t random_operands();
		in_t              item;
		int               kind;
		int               w;
		logic [FIELD_W-1:0] mask;
		logic [FIELD_W-1:0] g;
		kind = $urandom_range(0, 9);
		item.operand_a = $urandom;
		item.operand_b = $urandom;
		case (kind)
			2, 3, 4: begin
				// Shared factor, small cofactors: short runs with a nontrivial divisor
				g = $urandom_range(1, 65535);
				item.operand_a = g * $urandom_range(0, 4095);
				item.operand_b = g * $urandom_range(1, 4095);
			end
			5, 6: begin
				w = $urandom_range(1, 16);
				mask = (32'd1 << w) - 1;
				item.operand_a = item.operand_a & mask;
				item.operand_b = item.operand_b & mask;
			end
			7: begin
				item.operand_b = '0;
				if ($urandom_range(0, 3) == 0)
					item.operand_a = '0;
			end
			8: begin
				item.operand_a = item.operand_b * $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0)
					item.operand_b = '0;
			end
			9: begin
				item.operand_a = item.operand_a | 32'h8000_0000;
				item.operand_b = item.operand_b >> $urandom_range(0, 31);
			end
			default: ;
		endcase
		return item;
	endfunction

	task automatic send_item(in_t item, bit known, out_t typed_result);
		int gap;
		gap = steady_phase ? 0 : $urandom_range(0, MAX_WAIT);
		repeat (gap) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
		@(negedge clk);
		src_valid <= 1'b1;
		src_data  <= item;
		do @(posedge clk); while (!(src_valid && !src_stall));
		pending_gcd_q.push_back(known ? typed_result : expected_gcd(item));
	endtask

	task automatic drain_results();
		@(negedge clk);
		src_valid <= 1'b0;
		while (pending_gcd_q.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: raise dst_stall for a random hold before taking each result, with no hold in the steady phase
	initial forever begin
		int hold;
		hold = steady_phase ? 0 : $urandom_range(0, MAX_WAIT);
		repeat (hold) begin
			@(negedge clk);
			dst_stall <= 1'b1;
		end
		@(negedge clk);
		dst_stall <= 1'b0;
		do @(posedge clk); while (!(dst_valid && !dst_stall));
	end

	always @(posedge clk) begin
		out_t exp_val;
		if (arst_n && dst_valid && !dst_stall) begin
			if (pending_gcd_q.size() == 0) begin
				$display("%0t: unexpected transaction, actual divisor_out %h zero_operand %b",
					$time, dst_data.divisor_out, dst_data.zero_operand);
				error_count++;
			end else begin
				exp_val = pending_gcd_q.pop_front();
				if (dst_data.divisor_out !== exp_val.divisor_out) begin
					$display("%0t: divisor_out mismatch: expected %h, actual %h",
						$time, exp_val.divisor_out, dst_data.divisor_out);
					error_count++;
				end
				if (dst_data.zero_operand !== exp_val.zero_operand) begin
					$display("%0t: zero_operand mismatch: expected %b, actual %b",
						$time, exp_val.zero_operand, dst_data.zero_operand);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		out_t none;
		none = '0;

		directed_vectors.push_back(make_vector(32'd0, 32'd0, 1, 32'd0, 1));
		directed_vectors.push_back(make_vector(32'hFFFF_FFFF, 32'd0, 1, 32'hFFFF_FFFF, 1));
		directed_vectors.push_back(make_vector(32'd5, 32'd0, 1, 32'd5, 1));
		directed_vectors.push_back(make_vector(32'd0, 32'd7, 1, 32'd7, 0));
		directed_vectors.push_back(make_vector(32'd0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0));
		directed_vectors.push_back(make_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0));
		directed_vectors.push_back(make_vector(32'd1, 32'hFFFF_FFFF, 1, 32'd1, 0));
		directed_vectors.push_back(make_vector(32'hFFFF_FFFF, 32'd1, 1, 32'd1, 0));
		directed_vectors.push_back(make_vector(32'd7, 32'd7, 1, 32'd7, 0));
		directed_vectors.push_back(make_vector(32'd12, 32'd18, 1, 32'd6, 0));
		directed_vectors.push_back(make_vector(32'h8000_0000, 32'h4000_0000, 1, 32'h4000_0000, 0));
		directed_vectors.push_back(make_vector(32'hAAAA_AAAA, 32'h5555_5555, 1, 32'h5555_5555, 0));
		// Consecutive Fibonacci numbers: the longest remainder chain at this width
		directed_vectors.push_back(make_vector(32'd2971215073, 32'd1836311903, 0, 32'd0, 0));
		directed_vectors.push_back(make_vector(32'd1836311903, 32'd2971215073, 0, 32'd0, 0));
		directed_vectors.push_back(make_vector(32'd1, 32'd0, 0, 32'd0, 0));
		directed_vectors.push_back(make_vector(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'd0, 0));
		directed_vectors.push_back(make_vector(32'd1071, 32'd462, 0, 32'd0, 0));
		directed_vectors.push_back(make_vector(32'hFFFF_FFFE, 32'hFFFF_FFFC, 0, 32'd0, 0));

		repeat (RESET_CYC) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_vectors[i])
			send_item(directed_vectors[i].operands, directed_vectors[i].known,
				directed_vectors[i].result);
		drain_results();

		for (int n = 0; n < RANDOM_OPS; n++) begin
			// Switch between idling and back-to-back stretches
			if (n % 100 == 0)
				steady_phase = ($urandom_range(0, 3) == 0);
			if (n == RANDOM_OPS / 2)
				drain_results();
			send_item(random_operands(), 1'b0, none);
		end

		@(negedge clk);
		src_valid <= 1'b0;
		while (pending_gcd_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/egcd_pkg.sv
hw/rtl/egcd_datapath.sv
hw/rtl/egcd_ctrl.sv
hw/rtl/euclid_gcd_unit.sv
verif/euclid_gcd_unit_tb.sv
